>>> sv/assert_macros.svh
// Assertion macros for the RTL of the frame receiver, used by bsfr_core.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bsfr assertion failed");
`define BSFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bsfr assertion failed");
`else
`define BSFR_ASSERT(lbl, clk, rst_n, prop)
`define BSFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/bsfr_pkg.sv
// Package of the byte stuffed frame receiver: field widths, event codes,
// register map and the configuration struct. No dependencies.
`timescale 1ns / 1ps
package bsfr_pkg;
	localparam int BYTE_W = 8;
	localparam int POS_W = 9;
	localparam int OFF_W = 4;
	localparam int EV_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [EV_W-1:0] {
		EV_NONE    = 4'd0,
		EV_PAYLOAD = 4'd1,
		EV_GOOD    = 4'd2,
		EV_BADSUM  = 4'd3,
		EV_EMPTY   = 4'd4,
		EV_TRUNC   = 4'd5,
		EV_STRAY   = 4'd6,
		EV_CTRLESC = 4'd7,
		EV_START   = 4'd8
	} event_t;

	typedef enum logic [2:0] {
		REG_START_CODE  = 3'd0,
		REG_ESCAPE_CODE = 3'd1,
		REG_BCAST_ADDR  = 3'd2,
		REG_CMD_LEN_OFF = 3'd3,
		REG_BC_LEN_OFF  = 3'd4
	} reg_idx_t;

	localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd170;
	localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd255;
	localparam logic [BYTE_W-1:0] BCAST_ADDR_RST = 8'd112;
	localparam logic [OFF_W-1:0] CMD_LEN_OFF_RST = 4'd4;
	localparam logic [OFF_W-1:0] BC_LEN_OFF_RST = 4'd1;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] broadcast_address;
		logic [OFF_W-1:0]  command_length_offset;
		logic [OFF_W-1:0]  broadcast_length_offset;
	} cfg_t;
endpackage

>>> sv/bsfr_if.sv
// Valid/ready channel interfaces: raw link bytes in, receiver events out.
// Depends on bsfr_pkg for field widths.
`timescale 1ns / 1ps
interface bsfr_link_if;
	import bsfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] line_byte;
	modport source (output valid, output line_byte, input ready);
	modport sink (input valid, input line_byte, output ready);
endinterface

interface bsfr_res_if;
	import bsfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic [BYTE_W-1:0] data_byte;
	logic [POS_W-1:0]  byte_index;
	modport source (output valid, output event_res, output data_byte, output byte_index,
		input ready);
	modport sink (input valid, input event_res, input data_byte, input byte_index,
		output ready);
endinterface

>>> sv/bsfr_cfg.sv
// APB-style configuration registers of the frame receiver.
// Depends on bsfr_pkg.
`timescale 1ns / 1ps
module bsfr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsfr_pkg::ADDR_W-1:0] paddr,
	input  logic [bsfr_pkg::DATA_W-1:0] pwdata,
	output logic [bsfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output bsfr_pkg::cfg_t              cfg
);
	import bsfr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= START_CODE_RST;
			cfg_q.escape_code <= ESCAPE_CODE_RST;
			cfg_q.broadcast_address <= BCAST_ADDR_RST;
			cfg_q.command_length_offset <= CMD_LEN_OFF_RST;
			cfg_q.broadcast_length_offset <= BC_LEN_OFF_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_CODE:  cfg_q.start_code <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_CODE: cfg_q.escape_code <= pwdata[BYTE_W-1:0];
				REG_BCAST_ADDR:  cfg_q.broadcast_address <= pwdata[BYTE_W-1:0];
				REG_CMD_LEN_OFF: cfg_q.command_length_offset <= pwdata[OFF_W-1:0];
				REG_BC_LEN_OFF:  cfg_q.broadcast_length_offset <= pwdata[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_START_CODE:  prdata[BYTE_W-1:0] = cfg_q.start_code;
			REG_ESCAPE_CODE: prdata[BYTE_W-1:0] = cfg_q.escape_code;
			REG_BCAST_ADDR:  prdata[BYTE_W-1:0] = cfg_q.broadcast_address;
			REG_CMD_LEN_OFF: prdata[OFF_W-1:0] = cfg_q.command_length_offset;
			REG_BC_LEN_OFF:  prdata[OFF_W-1:0] = cfg_q.broadcast_length_offset;
			default:         prdata = '0;
		endcase
	end
endmodule

>>> sv/bsfr_core.sv
// Deframer datapath: input byte register, frame state and result register.
// Depends on bsfr_pkg, bsfr_if.sv and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bsfr_core (
	input  logic           clk,
	input  logic           arst_n,
	input  bsfr_pkg::cfg_t cfg,
	bsfr_link_if.sink      link,
	bsfr_res_if.source     res
);
	import bsfr_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;

	logic              inside_q, esc_q, bc_q;
	logic [POS_W-1:0]  pos_q, fend_q;
	logic [BYTE_W-1:0] sum_q;

	logic              inside_n, esc_n, bc_n;
	logic [POS_W-1:0]  pos_n, fend_n;
	logic [BYTE_W-1:0] sum_n;

	event_t            ev_n, pev;
	logic [BYTE_W-1:0] data_n, ub;
	logic [POS_W-1:0]  idx_n, cnt, fend_c;
	logic              take, bc_c;
	logic [OFF_W-1:0]  off;

	logic              res_valid_q;
	event_t            ev_q;
	logic [BYTE_W-1:0] data_q;
	logic [POS_W-1:0]  idx_q;

	assign adv = !res_valid_q || res.ready;
	assign link.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link.ready) begin
			valid_s1 <= link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link.ready && link.valid) begin
			byte_s1 <= link.line_byte;
		end
	end

	always_comb begin
		inside_n = inside_q;
		esc_n = esc_q;
		bc_n = bc_q;
		pos_n = pos_q;
		fend_n = fend_q;
		sum_n = sum_q;
		ev_n = EV_NONE;
		data_n = '0;
		idx_n = '0;
		take = 1'b0;
		pev = EV_PAYLOAD;
		ub = byte_s1;
		bc_c = bc_q;
		off = '0;
		fend_c = fend_q;
		cnt = pos_q + POS_W'(1);
		if (!inside_q) begin
			if (byte_s1 == cfg.start_code) begin
				inside_n = 1'b1;
				esc_n = 1'b0;
				bc_n = 1'b0;
				pos_n = '0;
				fend_n = '0;
				sum_n = '0;
				ev_n = EV_START;
			end else if (byte_s1 == cfg.escape_code) begin
				ev_n = EV_STRAY;
			end
		end else begin
			if (esc_q) begin
				esc_n = 1'b0;
				if (byte_s1 == cfg.start_code || byte_s1 == cfg.escape_code) begin
					pev = EV_CTRLESC;
				end
				ub = ~byte_s1;
				take = 1'b1;
			end else if (byte_s1 == cfg.escape_code) begin
				esc_n = 1'b1;
			end else if (byte_s1 == cfg.start_code) begin
				if (pos_q == '0) begin
					ev_n = EV_EMPTY;
				end else begin
					esc_n = 1'b0;
					bc_n = 1'b0;
					pos_n = '0;
					fend_n = '0;
					sum_n = '0;
					ev_n = EV_TRUNC;
				end
			end else begin
				take = 1'b1;
			end
			if (take) begin
				if (pos_q == '0) begin
					bc_c = (ub == cfg.broadcast_address);
				end
				off = bc_c ? cfg.broadcast_length_offset : cfg.command_length_offset;
				if (fend_q == '0 && pos_q == POS_W'(off)) begin
					fend_c = POS_W'(off) + POS_W'(ub) + POS_W'(2);
				end
				data_n = ub;
				idx_n = pos_q;
				if (fend_c != '0 && cnt == fend_c) begin
					ev_n = (sum_q == ub) ? EV_GOOD : EV_BADSUM;
					inside_n = 1'b0;
					esc_n = 1'b0;
					bc_n = 1'b0;
					pos_n = '0;
					fend_n = '0;
					sum_n = '0;
				end else begin
					ev_n = pev;
					sum_n = sum_q + ub;
					pos_n = cnt;
					bc_n = bc_c;
					fend_n = fend_c;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q <= 1'b0;
			bc_q <= 1'b0;
			pos_q <= '0;
			fend_q <= '0;
			sum_q <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				inside_q <= inside_n;
				esc_q <= esc_n;
				bc_q <= bc_n;
				pos_q <= pos_n;
				fend_q <= fend_n;
				sum_q <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			ev_q <= ev_n;
			data_q <= data_n;
			idx_q <= idx_n;
		end
	end

	assign res.valid = res_valid_q;
	assign res.event_res = ev_q;
	assign res.data_byte = data_q;
	assign res.byte_index = idx_q;

	`BSFR_ASSERT(a_esc_in_frame, clk, arst_n, !esc_q || inside_q)
	`BSFR_ASSERT(a_idle_clear, clk, arst_n, inside_q || (pos_q == '0 && fend_q == '0))
	`BSFR_ASSERT(a_fend_min, clk, arst_n, fend_q != POS_W'(1))
	`BSFR_ASSERT_NEXT(a_end_leaves, clk, arst_n,
		adv && valid_s1 && (ev_n == EV_GOOD || ev_n == EV_BADSUM), !inside_q)
endmodule

>>> sv/byte_stuffed_frame_receiver.sv
// Byte stuffed frame receiver, top level.
// Link side: one raw byte per request on the link channel (valid/ready).
// Result side: exactly one event per accepted byte on the res channel:
//   event_res, data_byte (unstuffed byte) and byte_index (position in frame).
// Registers (APB, byte address 4*i): start code, escape code, broadcast
//   address, command and broadcast length-byte offsets.
// Path: an accepted byte is held in the input register, then the frame
//   logic writes its event into the result register.
// Throughput: one byte per cycle while res is not held off; the frame
//   state update is combinational between the input and result registers.
// Stall: while res is held off, one byte waits in the input register and
//   link.ready drops; nothing is lost or reordered.
// Reset (arst_n low): registers return to their defaults, the receiver
//   hunts for a start code, and both channel stages are empty.
// Depends on bsfr_pkg, bsfr_if.sv, bsfr_cfg and bsfr_core.
`timescale 1ns / 1ps
module byte_stuffed_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	bsfr_link_if.sink                   link,
	bsfr_res_if.source                  res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsfr_pkg::ADDR_W-1:0] paddr,
	input  logic [bsfr_pkg::DATA_W-1:0] pwdata,
	output logic [bsfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import bsfr_pkg::*;

	cfg_t cfg;

	bsfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsfr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.link   (link),
		.res    (res)
	);
endmodule
